FILE: rtl/lds_pkg.sv
// package: shared types, codes and constants for the two-wire led display sender
`timescale 1ns / 1ps
`default_nettype none
package lds_pkg;

    localparam int unsigned DIGITS = 4;

    localparam logic [7:0] CMD_DATA_SET    = 8'h40;
    localparam logic [7:0] CMD_ADDRESS     = 8'hC0;
    localparam logic [7:0] CMD_DISPLAY     = 8'h80;
    localparam logic [3:0] MAX_LEVEL       = 4'd7;
    localparam logic [7:0] ACK_TIMEOUT_RST = 8'd16;

    // operation codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_SHOW  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_BRIGHT  = 2'd1;
    localparam logic [1:0] STAT_TIMEOUT = 2'd2;

    // byte positions within one display sequence
    localparam logic [2:0] POS_DATA_SET  = 3'd0;
    localparam logic [2:0] POS_ADDRESS   = 3'd1;
    localparam logic [2:0] POS_DIGIT_LO  = 3'd2;
    localparam logic [2:0] POS_DIGIT_HI  = 3'd5;
    localparam logic [2:0] POS_LAST_DIG  = 3'd4;
    localparam logic [2:0] POS_DISPLAY   = 3'd6;
    localparam logic [2:0] BIT_LAST      = 3'd7;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'd0,
        ST_START0 = 5'd1,
        ST_START1 = 5'd2,
        ST_START2 = 5'd3,
        ST_START3 = 5'd4,
        ST_BIT0   = 5'd5,
        ST_BIT1   = 5'd6,
        ST_BIT2   = 5'd7,
        ST_ACK0   = 5'd8,
        ST_ACK1   = 5'd9,
        ST_ACK2   = 5'd10,
        ST_WAIT   = 5'd11,
        ST_STOP0  = 5'd12,
        ST_STOP1  = 5'd13,
        ST_STOP2  = 5'd14,
        ST_STOP3  = 5'd15
    } t_step;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] digit_0;
        logic [7:0] digit_1;
        logic [7:0] digit_2;
        logic [7:0] digit_3;
        logic [3:0] brightness;
        logic       dio_sense;
    } t_item;

    typedef struct packed {
        logic       clk_level;
        logic       dio_level;
        logic       dio_drive;
        logic       busy_res;
        logic [1:0] status;
        logic       frame_done;
    } t_result;

    // byte sent at a given position of the sequence
    function automatic logic [7:0] byte_for(input logic [2:0] pos, input logic [7:0] digit,
                                            input logic [3:0] level);
        logic [7:0] b;
        if (pos == POS_DATA_SET) begin
            b = CMD_DATA_SET;
        end else if (pos == POS_ADDRESS) begin
            b = CMD_ADDRESS;
        end else if (pos >= POS_DIGIT_LO && pos <= POS_DIGIT_HI) begin
            b = digit;
        end else begin
            b = CMD_DISPLAY | {4'd0, level};
        end
        return b;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/lds_if.sv
// interfaces: request, result and configuration channels
`timescale 1ns / 1ps
`default_nettype none
interface lds_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] digit_0;
    logic [7:0] digit_1;
    logic [7:0] digit_2;
    logic [7:0] digit_3;
    logic [3:0] brightness;
    logic       dio_sense;

    modport source (output valid, operation, digit_0, digit_1, digit_2, digit_3,
                    brightness, dio_sense, input ready);
    modport sink (input valid, operation, digit_0, digit_1, digit_2, digit_3,
                  brightness, dio_sense, output ready);
endinterface

interface lds_out_if;
    logic       valid;
    logic       ready;
    logic       clk_level;
    logic       dio_level;
    logic       dio_drive;
    logic       busy_res;
    logic [1:0] status;
    logic       frame_done;

    modport source (output valid, clk_level, dio_level, dio_drive, busy_res, status,
                    frame_done, input ready);
    modport sink (input valid, clk_level, dio_level, dio_drive, busy_res, status,
                  frame_done, output ready);
endinterface

interface lds_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/lds_seq.sv
// pin sequencer: state registers and one pin step per accepted tick request
`timescale 1ns / 1ps
`default_nettype none
module lds_seq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire lds_pkg::t_item  i_item,
    input  wire logic [7:0]      i_ack_timeout,
    output lds_pkg::t_result     o_result
);
    import lds_pkg::*;

    t_step      r_step, n_step;
    logic [2:0] r_bit_pos, n_bit_pos;
    logic [2:0] r_byte_pos, n_byte_pos;
    logic [7:0] r_shift, n_shift;
    logic [7:0] r_digit [DIGITS];
    logic [7:0] n_digit [DIGITS];
    logic [3:0] r_level, n_level;
    logic [7:0] r_wait, n_wait;
    logic       r_clk_pin, n_clk_pin;
    logic       r_dio_pin, n_dio_pin;
    logic       r_drive, n_drive;
    logic [1:0] r_status, n_status;

    logic [2:0] w_load_pos;
    logic [1:0] w_dig_idx;
    logic [7:0] w_load_byte;
    logic [7:0] w_wait_inc;
    logic [7:0] w_limit;
    logic       w_ack_done;
    logic       w_frame_done;

    // byte to load: current position after start, next position after an ack
    assign w_load_pos  = (r_step == ST_WAIT) ? r_byte_pos + 3'd1 : r_byte_pos;
    assign w_dig_idx   = w_load_pos[1:0] - POS_DIGIT_LO[1:0];
    assign w_load_byte = byte_for(w_load_pos, r_digit[w_dig_idx], r_level);
    assign w_wait_inc  = r_wait + 8'd1;
    assign w_limit     = (i_ack_timeout == 8'd0) ? 8'd1 : i_ack_timeout;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step     <= ST_IDLE;
            r_bit_pos  <= '0;
            r_byte_pos <= '0;
            r_shift    <= '0;
            r_level    <= '0;
            r_wait     <= '0;
            r_clk_pin  <= 1'b1;
            r_dio_pin  <= 1'b1;
            r_drive    <= 1'b1;
            r_status   <= STAT_OK;
        end else begin
            r_step     <= n_step;
            r_bit_pos  <= n_bit_pos;
            r_byte_pos <= n_byte_pos;
            r_shift    <= n_shift;
            r_level    <= n_level;
            r_wait     <= n_wait;
            r_clk_pin  <= n_clk_pin;
            r_dio_pin  <= n_dio_pin;
            r_drive    <= n_drive;
            r_status   <= n_status;
        end
    end

    // digit store is always loaded by a request before it is read
    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

    always_comb begin
        n_step       = r_step;
        n_bit_pos    = r_bit_pos;
        n_byte_pos   = r_byte_pos;
        n_shift      = r_shift;
        n_digit      = r_digit;
        n_level      = r_level;
        n_wait       = r_wait;
        n_clk_pin    = r_clk_pin;
        n_dio_pin    = r_dio_pin;
        n_drive      = r_drive;
        n_status     = r_status;
        w_ack_done   = 1'b0;
        w_frame_done = 1'b0;

        if (i_accept) begin
            case (i_item.operation) inside
                OP_TICK: begin
                    unique case (r_step)
                        ST_IDLE: begin
                        end
                        ST_START0: begin
                            n_drive   = 1'b1;
                            n_clk_pin = 1'b1;
                            n_step    = ST_START1;
                        end
                        ST_START1: begin
                            n_drive   = 1'b1;
                            n_dio_pin = 1'b1;
                            n_step    = ST_START2;
                        end
                        ST_START2: begin
                            n_drive   = 1'b1;
                            n_dio_pin = 1'b0;
                            n_step    = ST_START3;
                        end
                        ST_START3: begin
                            n_drive   = 1'b1;
                            n_clk_pin = 1'b0;
                            n_shift   = w_load_byte;
                            n_bit_pos = '0;
                            n_step    = ST_BIT0;
                        end
                        ST_BIT0: begin
                            n_clk_pin = 1'b0;
                            n_step    = ST_BIT1;
                        end
                        ST_BIT1: begin
                            n_drive   = 1'b1;
                            n_dio_pin = r_shift[r_bit_pos];
                            n_step    = ST_BIT2;
                        end
                        ST_BIT2: begin
                            n_clk_pin = 1'b1;
                            if (r_bit_pos == BIT_LAST) begin
                                n_bit_pos = '0;
                                n_step    = ST_ACK0;
                            end else begin
                                n_bit_pos = r_bit_pos + 3'd1;
                                n_step    = ST_BIT0;
                            end
                        end
                        ST_ACK0: begin
                            n_clk_pin = 1'b0;
                            n_drive   = 1'b0;
                            n_step    = ST_ACK1;
                        end
                        ST_ACK1: begin
                            n_clk_pin = 1'b1;
                            n_step    = ST_ACK2;
                        end
                        ST_ACK2: begin
                            n_clk_pin = 1'b0;
                            n_wait    = '0;
                            n_step    = ST_WAIT;
                        end
                        ST_WAIT: begin
                            if (!i_item.dio_sense) begin
                                w_ack_done = 1'b1;
                            end else begin
                                n_wait = w_wait_inc;
                                if (w_wait_inc >= w_limit) begin
                                    n_status   = STAT_TIMEOUT;
                                    w_ack_done = 1'b1;
                                end
                            end
                            if (w_ack_done) begin
                                n_wait    = '0;
                                n_drive   = 1'b1;
                                n_dio_pin = 1'b0;
                                // address and first three digits chain straight on
                                if (r_byte_pos >= POS_ADDRESS && r_byte_pos <= POS_LAST_DIG) begin
                                    n_byte_pos = w_load_pos;
                                    n_shift    = w_load_byte;
                                    n_bit_pos  = '0;
                                    n_step     = ST_BIT0;
                                end else begin
                                    n_step = ST_STOP0;
                                end
                            end
                        end
                        ST_STOP0: begin
                            n_drive   = 1'b1;
                            n_clk_pin = 1'b0;
                            n_step    = ST_STOP1;
                        end
                        ST_STOP1: begin
                            n_drive   = 1'b1;
                            n_dio_pin = 1'b0;
                            n_step    = ST_STOP2;
                        end
                        ST_STOP2: begin
                            n_drive   = 1'b1;
                            n_clk_pin = 1'b1;
                            n_step    = ST_STOP3;
                        end
                        ST_STOP3: begin
                            n_drive   = 1'b1;
                            n_dio_pin = 1'b1;
                            if (r_byte_pos >= POS_DISPLAY) begin
                                n_step       = ST_IDLE;
                                n_byte_pos   = '0;
                                w_frame_done = 1'b1;
                            end else begin
                                n_byte_pos = r_byte_pos + 3'd1;
                                n_step     = ST_START0;
                            end
                        end
                        default: begin
                            n_step = ST_IDLE;
                        end
                    endcase
                end
                OP_SHOW, OP_CLEAR: begin
                    if (r_step == ST_IDLE) begin
                        if (i_item.operation == OP_SHOW && i_item.brightness > MAX_LEVEL) begin
                            n_status = STAT_BRIGHT;
                        end else begin
                            if (i_item.operation == OP_SHOW) begin
                                n_digit[0] = i_item.digit_0;
                                n_digit[1] = i_item.digit_1;
                                n_digit[2] = i_item.digit_2;
                                n_digit[3] = i_item.digit_3;
                                n_level    = {1'b1, i_item.brightness[2:0]};
                            end else begin
                                for (int i = 0; i < DIGITS; i++) begin
                                    n_digit[i] = '0;
                                end
                                n_level = '0;
                            end
                            n_status   = STAT_OK;
                            n_byte_pos = '0;
                            n_bit_pos  = '0;
                            n_wait     = '0;
                            n_step     = ST_START0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        o_result.clk_level  = n_clk_pin;
        o_result.dio_level  = n_dio_pin;
        o_result.dio_drive  = n_drive;
        o_result.busy_res   = (n_step != ST_IDLE);
        o_result.status     = n_status;
        o_result.frame_done = w_frame_done;
    end

endmodule
`default_nettype wire

FILE: rtl/led_display_two_wire_sender_top.sv
// top level: two-wire led display sender with result register and config register
// latency: a request's result is valid in the cycle after it is accepted
// throughput: one request per cycle while results are taken; the single result register frees as it is taken
// each tick request moves the pins one step through the pin sequencer in one pass
// reset (synchronous, active low): sequencer idle, pins clock and data high and driven,
// status ok, no result pending, acknowledge timeout 16
`timescale 1ns / 1ps
`default_nettype none
module led_display_two_wire_sender_top (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lds_in_if.sink    i_req,
    lds_out_if.source o_res,
    lds_cfg_if.sink   i_cfg
);
    import lds_pkg::*;

    logic       r_out_valid;
    t_result    r_out;
    logic [7:0] r_ack_timeout;

    logic       w_in_ready;
    logic       w_accept;
    t_item      w_item;
    t_result    w_result;

    // result register: a new request goes in whenever the slot is empty or being taken
    assign w_in_ready  = !r_out_valid || o_res.ready;
    assign w_accept    = i_req.valid && w_in_ready;
    assign i_req.ready = w_in_ready;

    // configuration is taken at any time
    assign i_cfg.ready = 1'b1;

    assign w_item = {i_req.operation, i_req.digit_0, i_req.digit_1, i_req.digit_2,
                     i_req.digit_3, i_req.brightness, i_req.dio_sense};

    // pin sequencer, steps only on an accepted request
    lds_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_item        (w_item),
        .i_ack_timeout (r_ack_timeout),
        .o_result      (w_result)
    );

    // acknowledge timeout register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_timeout <= ACK_TIMEOUT_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_ack_timeout <= i_cfg.data;
        end
    end

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= w_result;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.clk_level  = r_out.clk_level;
    assign o_res.dio_level  = r_out.dio_level;
    assign o_res.dio_drive  = r_out.dio_drive;
    assign o_res.busy_res   = r_out.busy_res;
    assign o_res.status     = r_out.status;
    assign o_res.frame_done = r_out.frame_done;

    // a finished sequence leaves the sender idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.frame_done |-> !r_out.busy_res)
        else $error("frame_done while still busy");

    // the data pin is only released inside a transfer
    a_release_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.dio_drive |-> r_out.busy_res)
        else $error("data pin released while idle");

    // a stalled result blocks new requests
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_res.ready |-> !i_req.ready)
        else $error("request taken while result stalled");

    // an accepted request makes its result valid in the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_out_valid)
        else $error("accepted request produced no result");

endmodule
`default_nettype wire

FILE: dv/lds_pin_checker.sv
// checker: predicts pin steps of the led display sender and compares every result
`timescale 1ns / 1ps
module lds_pin_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lds_in_if         i_req,
    lds_out_if        i_res,
    lds_cfg_if        i_cfg,
    output int        o_errors,
    output int        o_pending,
    output int        o_requests,
    output int        o_compared,
    output int        o_frames,
    output int        o_timeouts,
    output logic      o_seq_active
);
    import lds_pkg::*;

    localparam logic [3:0] LEVEL_ON = 4'h8;

    // predicted sequencer state
    t_step      step_now;
    logic [2:0] bit_idx;
    logic [2:0] byte_idx;
    logic [7:0] shift_reg;
    logic [7:0] digit_mem [DIGITS];
    logic [3:0] level_mem;
    logic [7:0] ack_wait;
    logic       pin_clk;
    logic       pin_dio;
    logic       pin_drv;
    logic [1:0] status_now;
    logic [7:0] ack_limit;

    t_result    pins_due [$];

    int mismatches     = 0;
    int requests_seen  = 0;
    int results_seen   = 0;
    int sequences_done = 0;
    int ack_timeouts   = 0;

    assign o_errors     = mismatches;
    assign o_pending    = pins_due.size();
    assign o_requests   = requests_seen;
    assign o_compared   = results_seen;
    assign o_frames     = sequences_done;
    assign o_timeouts   = ack_timeouts;
    assign o_seq_active = step_now != ST_IDLE;

    function automatic logic [7:0] wire_byte(input logic [2:0] pos);
        if (pos == POS_DATA_SET) return CMD_DATA_SET;
        if (pos == POS_ADDRESS) return CMD_ADDRESS;
        if (pos >= POS_DIGIT_LO && pos <= POS_DIGIT_HI) return digit_mem[2'(pos - POS_DIGIT_LO)];
        return CMD_DISPLAY | {4'd0, level_mem};
    endfunction

    function automatic void next_byte();
        shift_reg = wire_byte(byte_idx);
        bit_idx   = '0;
        step_now  = ST_BIT0;
    endfunction

    // one pin step, returns 1 when the whole sequence has just ended
    function automatic logic pin_step(input logic sense);
        logic       fin;
        logic       hit;
        logic [7:0] limit;
        fin   = 1'b0;
        hit   = 1'b0;
        limit = (ack_limit == 8'd0) ? 8'd1 : ack_limit;
        case (step_now)
            ST_IDLE: begin
            end
            ST_START0: begin
                pin_drv  = 1'b1;
                pin_clk  = 1'b1;
                step_now = ST_START1;
            end
            ST_START1: begin
                pin_drv  = 1'b1;
                pin_dio  = 1'b1;
                step_now = ST_START2;
            end
            ST_START2: begin
                pin_drv  = 1'b1;
                pin_dio  = 1'b0;
                step_now = ST_START3;
            end
            ST_START3: begin
                pin_drv = 1'b1;
                pin_clk = 1'b0;
                next_byte();
            end
            ST_BIT0: begin
                pin_clk  = 1'b0;
                step_now = ST_BIT1;
            end
            ST_BIT1: begin
                pin_drv  = 1'b1;
                pin_dio  = shift_reg[bit_idx];
                step_now = ST_BIT2;
            end
            ST_BIT2: begin
                pin_clk = 1'b1;
                if (bit_idx == BIT_LAST) begin
                    bit_idx  = '0;
                    step_now = ST_ACK0;
                end else begin
                    bit_idx  = bit_idx + 3'd1;
                    step_now = ST_BIT0;
                end
            end
            ST_ACK0: begin
                pin_clk  = 1'b0;
                pin_drv  = 1'b0;
                step_now = ST_ACK1;
            end
            ST_ACK1: begin
                pin_clk  = 1'b1;
                step_now = ST_ACK2;
            end
            ST_ACK2: begin
                pin_clk  = 1'b0;
                ack_wait = '0;
                step_now = ST_WAIT;
            end
            ST_WAIT: begin
                if (!sense) begin
                    hit = 1'b1;
                end else begin
                    ack_wait = ack_wait + 8'd1;
                    if (ack_wait >= limit) begin
                        status_now = STAT_TIMEOUT;
                        hit        = 1'b1;
                        ack_timeouts++;
                    end
                end
                if (hit) begin
                    ack_wait = '0;
                    pin_drv  = 1'b1;
                    pin_dio  = 1'b0;
                    // address and first three digits run straight into the next byte
                    if (byte_idx >= POS_ADDRESS && byte_idx <= POS_LAST_DIG) begin
                        byte_idx = byte_idx + 3'd1;
                        next_byte();
                    end else begin
                        step_now = ST_STOP0;
                    end
                end
            end
            ST_STOP0: begin
                pin_drv  = 1'b1;
                pin_clk  = 1'b0;
                step_now = ST_STOP1;
            end
            ST_STOP1: begin
                pin_drv  = 1'b1;
                pin_dio  = 1'b0;
                step_now = ST_STOP2;
            end
            ST_STOP2: begin
                pin_drv  = 1'b1;
                pin_clk  = 1'b1;
                step_now = ST_STOP3;
            end
            ST_STOP3: begin
                pin_drv = 1'b1;
                pin_dio = 1'b1;
                if (byte_idx >= POS_DISPLAY) begin
                    step_now = ST_IDLE;
                    byte_idx = '0;
                    fin      = 1'b1;
                end else begin
                    byte_idx = byte_idx + 3'd1;
                    step_now = ST_START0;
                end
            end
            default: step_now = ST_IDLE;
        endcase
        return fin;
    endfunction

    function automatic t_result predict_request(input t_item it);
        t_result r;
        logic    fin;
        logic    was_busy;
        logic    show;
        fin      = 1'b0;
        was_busy = step_now != ST_IDLE;
        show     = it.operation == OP_SHOW;
        if (it.operation == OP_TICK) begin
            fin = pin_step(it.dio_sense);
        end else if ((show || it.operation == OP_CLEAR) && !was_busy) begin
            if (show && it.brightness > MAX_LEVEL) begin
                status_now = STAT_BRIGHT;
            end else begin
                digit_mem[0] = show ? it.digit_0 : 8'd0;
                digit_mem[1] = show ? it.digit_1 : 8'd0;
                digit_mem[2] = show ? it.digit_2 : 8'd0;
                digit_mem[3] = show ? it.digit_3 : 8'd0;
                level_mem    = show ? (LEVEL_ON | it.brightness) : 4'd0;
                status_now   = STAT_OK;
                byte_idx     = '0;
                bit_idx      = '0;
                ack_wait     = '0;
                step_now     = ST_START0;
            end
        end
        if (fin) sequences_done++;
        r.clk_level  = pin_clk;
        r.dio_level  = pin_dio;
        r.dio_drive  = pin_drv;
        r.busy_res   = step_now != ST_IDLE;
        r.status     = status_now;
        r.frame_done = fin;
        return r;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_item   seen;
        t_result want;
        if (!i_rst_n) begin
            step_now   = ST_IDLE;
            bit_idx    = '0;
            byte_idx   = '0;
            shift_reg  = '0;
            for (int i = 0; i < DIGITS; i++) digit_mem[i] = '0;
            level_mem  = '0;
            ack_wait   = '0;
            pin_clk    = 1'b1;
            pin_dio    = 1'b1;
            pin_drv    = 1'b1;
            status_now = STAT_OK;
            ack_limit  = ACK_TIMEOUT_RST;
            pins_due.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (pins_due.size() == 0) begin
                    $error("result with nothing expected");
                    mismatches++;
                end else begin
                    want = pins_due.pop_front();
                    results_seen++;
                    check_field("clk_level", want.clk_level, i_res.clk_level);
                    check_field("dio_level", want.dio_level, i_res.dio_level);
                    check_field("dio_drive", want.dio_drive, i_res.dio_drive);
                    check_field("busy_res", want.busy_res, i_res.busy_res);
                    check_field("status", want.status, i_res.status);
                    check_field("frame_done", want.frame_done, i_res.frame_done);
                end
            end
            // a request taken at this edge still sees the old timeout
            if (i_req.valid && i_req.ready) begin
                seen.operation  = i_req.operation;
                seen.digit_0    = i_req.digit_0;
                seen.digit_1    = i_req.digit_1;
                seen.digit_2    = i_req.digit_2;
                seen.digit_3    = i_req.digit_3;
                seen.brightness = i_req.brightness;
                seen.dio_sense  = i_req.dio_sense;
                pins_due.push_back(predict_request(seen));
                requests_seen++;
            end
            if (i_cfg.valid && i_cfg.ready) ack_limit = i_cfg.data;
        end
    end

endmodule

FILE: dv/tb_top.sv
// testbench top: request stimulus, result back-pressure and verdict for the led display sender
`timescale 1ns / 1ps
module tb_top;
    import lds_pkg::*;

    localparam int HALF_PERIOD     = 5;
    localparam int RESET_CYCLES    = 10;
    // longest quiet stretch is the receiver hold-off plus random gaps, taken several times
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    // a result is valid in the cycle after its request; the settle cycles catch stray results
    localparam int SETTLE_CYCLES   = 4;
    localparam int PHASE_ITEMS     = 150;

    // operation code three is not named by the package: the block treats it as a hold
    localparam logic [1:0] OP_HOLD = 2'd3;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    lds_in_if  req();
    lds_out_if res();
    lds_cfg_if cfg();

    int   errors;
    int   pending;
    int   requests;
    int   compared;
    int   frames;
    int   timeouts;
    logic seq_active;

    // idle chances in percent, changed per phase by the stimulus
    int send_gap_pct = 0;
    int take_gap_pct = 0;
    // each bump asks the receiver for one long hold-off
    int hold_asks    = 0;
    int quiet_cycles = 0;

    always #HALF_PERIOD clk = ~clk;

    led_display_two_wire_sender_top i_dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_req  (req),
        .o_res  (res),
        .i_cfg  (cfg)
    );

    lds_pin_checker i_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req       (req),
        .i_res       (res),
        .i_cfg       (cfg),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_requests  (requests),
        .o_compared  (compared),
        .o_frames    (frames),
        .o_timeouts  (timeouts),
        .o_seq_active(seq_active)
    );

    // ---------------------------------------------------------------------------------------
    // result side: random stalls, plus a long hold-off counted here so the block backs up
    // ---------------------------------------------------------------------------------------
    initial begin : taker
        int hold_served;
        int hold_left;
        hold_served = 0;
        hold_left   = 0;
        res.ready <= 1'b0;
        forever begin
            @(negedge clk);
            if (hold_asks != hold_served) begin
                hold_served = hold_asks;
                hold_left   = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                res.ready <= 1'b0;
                hold_left--;
            end else begin
                res.ready <= ($urandom_range(99) >= take_gap_pct);
            end
        end
    end

    // watchdog: any handshake restarts the count, reset counts as activity
    always @(posedge clk) begin
        if (!rst_n || (req.valid && req.ready) || (res.valid && res.ready)
                || (cfg.valid && cfg.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------------------------------------------------------------------------------
    // request driving: every task is entered and left just after a falling edge
    // ---------------------------------------------------------------------------------------

    // offer one request, with random idle cycles first; valid stays high on exit so
    // back-to-back requests need no extra drop
    task automatic push_request(input t_item it);
        while ($urandom_range(99) < send_gap_pct) begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid      <= 1'b1;
        req.operation  <= it.operation;
        req.digit_0    <= it.digit_0;
        req.digit_1    <= it.digit_1;
        req.digit_2    <= it.digit_2;
        req.digit_3    <= it.digit_3;
        req.brightness <= it.brightness;
        req.dio_sense  <= it.dio_sense;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        @(negedge clk);
    endtask

    // request with random payload; the block ignores the fields the operation does not use
    function automatic t_item random_item(input logic [1:0] op);
        t_item it;
        it.operation  = op;
        it.digit_0    = 8'($urandom_range(0, 255));
        it.digit_1    = 8'($urandom_range(0, 255));
        it.digit_2    = 8'($urandom_range(0, 255));
        it.digit_3    = 8'($urandom_range(0, 255));
        it.brightness = 4'($urandom_range(0, 15));
        it.dio_sense  = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic t_item make_request(input logic [1:0] op, input logic [7:0] d0,
                                           input logic [7:0] d1, input logic [7:0] d2,
                                           input logic [7:0] d3, input logic [3:0] level);
        t_item it;
        it.operation  = op;
        it.digit_0    = d0;
        it.digit_1    = d1;
        it.digit_2    = d2;
        it.digit_3    = d3;
        it.brightness = level;
        it.dio_sense  = 1'b0;
        return it;
    endfunction

    // show or clear that opens a sequence; a few shows carry a rejected brightness
    function automatic t_item fresh_request();
        t_item it;
        int    pick;
        pick = $urandom_range(0, 99);
        it   = random_item(pick < 75 ? OP_SHOW : OP_CLEAR);
        if (it.operation == OP_SHOW) begin
            it.brightness = (pick < 65) ? 4'($urandom_range(0, 7)) : 4'($urandom_range(8, 15));
        end
        return it;
    endfunction

    // one pin step with the given sensed data level
    task automatic pin_tick(input logic sense);
        t_item it;
        it           = random_item(OP_TICK);
        it.dio_sense = sense;
        push_request(it);
    endtask

    // step the link until the sequencer is back to idle
    task automatic drain_link(input int high_pct);
        while (seq_active) pin_tick($urandom_range(99) < high_pct);
    endtask

    // register write only with the link idle and every result in
    task automatic set_ack_timeout(input logic [7:0] ticks);
        req.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.data  <= ticks;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    // mostly whole sequences with random digits and sensed levels, some noise in between;
    // requests made while busy are dropped by the block and are not counted
    task automatic random_phase(input int budget, input int high_pct);
        int    done_items;
        logic [1:0] noise_op;
        done_items = 0;
        while (done_items < budget) begin
            if ($urandom_range(99) < 80) begin
                push_request(fresh_request());
                done_items++;
                while (seq_active) begin
                    if ($urandom_range(99) < 3) begin
                        noise_op = ($urandom_range(1) != 0) ? OP_SHOW : OP_CLEAR;
                        if ($urandom_range(3) == 0) noise_op = OP_HOLD;
                        push_request(random_item(noise_op));
                    end else begin
                        pin_tick($urandom_range(99) < high_pct);
                        done_items++;
                    end
                end
            end else begin
                // idle noise: ticks with the link quiet, or hold codes
                if ($urandom_range(1) != 0) begin
                    pin_tick($urandom_range(1) != 0);
                end else begin
                    push_request(random_item(OP_HOLD));
                end
                done_items++;
            end
        end
        drain_link(0);
    endtask

    // ---------------------------------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------------------------------
    initial begin : stimulus
        req.valid      <= 1'b0;
        req.operation  <= OP_TICK;
        req.digit_0    <= '0;
        req.digit_1    <= '0;
        req.digit_2    <= '0;
        req.digit_3    <= '0;
        req.brightness <= '0;
        req.dio_sense  <= 1'b0;
        cfg.valid      <= 1'b0;
        cfg.data       <= '0;

        // synchronous reset, released on a falling edge
        rst_n <= 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // sender 24 / receiver 55 idle first, from the directed part on
        send_gap_pct = 24;
        take_gap_pct = 55;

        // directed: ticks with the link idle, hold code, rejected brightness
        pin_tick(1'b0);
        pin_tick(1'b1);
        push_request(make_request(OP_HOLD, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 4'hF));
        push_request(make_request(OP_SHOW, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 4'd8));
        push_request(make_request(OP_SHOW, 8'h00, 8'h00, 8'h00, 8'h00, 4'hF));

        // directed: accepted show at lowest brightness, then requests dropped while busy
        push_request(make_request(OP_SHOW, 8'h00, 8'hFF, 8'hA5, 8'h5A, 4'd0));
        push_request(make_request(OP_SHOW, 8'hFF, 8'h00, 8'h5A, 8'hA5, 4'd7));
        push_request(make_request(OP_CLEAR, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 4'hF));
        push_request(make_request(OP_HOLD, 8'h00, 8'h00, 8'h00, 8'h00, 4'h0));
        drain_link(0);

        // directed: clear with the data line stuck high, every acknowledge times out
        push_request(make_request(OP_CLEAR, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 4'hF));
        drain_link(100);

        // random phases, same idle rates
        set_ack_timeout(8'd255);
        random_phase(PHASE_ITEMS, 5);

        // long receiver hold-off while requests keep coming
        set_ack_timeout(8'd1);
        hold_asks <= hold_asks + 1;
        random_phase(PHASE_ITEMS, 50);

        // swapped idle rates; zero timeout behaves as one tick
        send_gap_pct = 55;
        take_gap_pct = 24;
        set_ack_timeout(8'd0);
        random_phase(PHASE_ITEMS, 60);

        set_ack_timeout(8'($urandom_range(2, 254)));
        random_phase(PHASE_ITEMS, 20);

        // no idling on either side, second hold-off fills the block again
        send_gap_pct = 0;
        take_gap_pct = 0;
        set_ack_timeout(8'd3);
        hold_asks <= hold_asks + 1;
        random_phase(PHASE_ITEMS, 40);

        set_ack_timeout(ACK_TIMEOUT_RST);
        random_phase(PHASE_ITEMS, 30);

        // wind down: wait for every result, then the settle cycles for anything stray
        req.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("covered %0d requests, %0d results checked, %0d show/clear sequences done",
                 requests, compared, frames);
        $display("ack timeouts hit %0d times across timeout settings 0, 1, 3, 16, 255 and random",
                 timeouts);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
